// ----- rtl/eds_pkg.sv -----
`default_nettype none
// ============================================================================
// eds_pkg
// Shared types, constants and helpers for the 3D explicit diffusion stencil.
// ============================================================================
package eds_pkg;

  // Grid limits
  localparam int MAX_NX = 64;
  localparam int MAX_NY = 64;
  localparam int MAX_NZ = 64;
  localparam int MIN_DIM = 3;

  // Field widths
  localparam int VAL_W     = 32;
  localparam int COEF_W    = 24;
  localparam int DIM_W     = 7;
  localparam int COORD_W   = 6;
  localparam int CFG_IDX_W = 3;

  // Window history: two planes plus one cell
  localparam int WIN_DEPTH = 2 * MAX_NX * MAX_NY + 1;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int PLANE_W   = $clog2(MAX_NX * MAX_NY + 1);

  // Arithmetic widths: Q16.16 values, Q0.24 coefficients
  localparam int FRAC_SHIFT = 24;
  localparam int DIFF_W     = VAL_W + 2;
  localparam int PROD_W     = DIFF_W + COEF_W + 1;
  localparam int ACC_W      = PROD_W + 3;
  localparam int RES_W      = ACC_W - FRAC_SHIFT;

  localparam logic [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_X  = 3'd0,
    CFG_COEF_Y  = 3'd1,
    CFG_COEF_Z  = 3'd2,
    CFG_GRID_NX = 3'd3,
    CFG_GRID_NY = 3'd4
  } cfg_idx_t;

  // Input transaction
  typedef struct packed {
    logic signed [VAL_W-1:0] cell_value;
    logic                    grid_start;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic signed [VAL_W-1:0] updated_value;
    logic [COORD_W-1:0]      cell_x;
    logic [COORD_W-1:0]      cell_y;
    logic [COORD_W-1:0]      cell_z;
  } out_item_t;

  // Clamped grid dimensions and plane size
  typedef struct packed {
    logic [DIM_W-1:0]   nx;
    logic [DIM_W-1:0]   ny;
    logic [PLANE_W-1:0] plane;
  } dims_t;

  // Diffusion coefficients
  typedef struct packed {
    logic [COEF_W-1:0] cx;
    logic [COEF_W-1:0] cy;
    logic [COEF_W-1:0] cz;
  } coefs_t;

  // Neighborhood of one interior center
  typedef struct packed {
    logic signed [VAL_W-1:0] c;
    logic signed [VAL_W-1:0] xm;
    logic signed [VAL_W-1:0] xp;
    logic signed [VAL_W-1:0] ym;
    logic signed [VAL_W-1:0] yp;
    logic signed [VAL_W-1:0] zm;
    logic signed [VAL_W-1:0] zp;
    logic [COORD_W-1:0]      cell_x;
    logic [COORD_W-1:0]      cell_y;
    logic [COORD_W-1:0]      cell_z;
  } taps_t;

  // Clamp a dimension register to [MIN_DIM, hi]
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    logic [DIM_W-1:0] r;
    if (int'(v) < MIN_DIM) begin
      r = DIM_W'(MIN_DIM);
    end else if (int'(v) > hi) begin
      r = DIM_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/eds_window.sv -----
`default_nettype none
// ============================================================================
// eds_window
// Raster position tracking, two-plane history store and neighbor fetch.
// The history is kept in three identical banks, each read at two addresses,
// so all six stored neighbors are read out in the same cycle.
// ============================================================================
module eds_window (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire eds_pkg::in_item_t  in_data,
  input  wire eds_pkg::dims_t     dims,
  output logic                    s1_valid,
  input  wire logic               s1_ready,
  output eds_pkg::taps_t          s1_taps
);

  localparam int AW = eds_pkg::WIN_AW;
  localparam int CW = eds_pkg::COORD_W;
  localparam int DW = eds_pkg::DIM_W;
  localparam int VW = eds_pkg::VAL_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(eds_pkg::WIN_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(eds_pkg::WIN_DEPTH);

  // Address of the entry d cells back from the write pointer
  function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wp, input logic [AW-1:0] d);
    logic [AW:0] diff;
    diff = {1'b0, wp} - {1'b0, d};
    if (diff[AW]) begin
      diff = diff + DEPTH_EXT;
    end
    return diff[AW-1:0];
  endfunction

  logic [CW-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [CW-1:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;

  logic [CW-1:0] cx, cy, cz;
  logic          interior;
  logic          accept;
  logic          load_taps;

  logic [AW-1:0] d_c, d_xp, d_xm, d_yp, d_ym, d_zm;
  logic [AW-1:0] a_c, a_xp, a_xm, a_yp, a_ym, a_zm;

  logic [VW-1:0] mem0 [eds_pkg::WIN_DEPTH];
  logic [VW-1:0] mem1 [eds_pkg::WIN_DEPTH];
  logic [VW-1:0] mem2 [eds_pkg::WIN_DEPTH];

  logic [VW-1:0] c_r, xp_r, xm_r, yp_r, ym_r, zm_r, zp_r;
  logic [CW-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic          s1_valid_r;

  // Handshake
  assign in_ready  = !s1_valid_r || s1_ready;
  assign accept    = in_valid && in_ready;
  assign load_taps = accept && interior;

  // Position of the arriving cell
  always_comb begin
    cx = in_data.grid_start ? '0 : pos_x_r;
    cy = in_data.grid_start ? '0 : pos_y_r;
    cz = in_data.grid_start ? '0 : pos_z_r;
  end

  // Interior test for the center one plane back
  assign interior = (cz >= CW'(2)) && (cx != '0) && (cy != '0) &&
                    (({1'b0, cx} + DW'(2)) <= dims.nx) &&
                    (({1'b0, cy} + DW'(2)) <= dims.ny);

  // Next raster position
  always_comb begin
    pos_x_nxt = cx + CW'(1);
    pos_y_nxt = cy;
    pos_z_nxt = cz;
    if (({1'b0, cx} + DW'(1)) >= dims.nx) begin
      pos_x_nxt = '0;
      pos_y_nxt = cy + CW'(1);
      if (({1'b0, cy} + DW'(1)) >= dims.ny) begin
        pos_y_nxt = '0;
        pos_z_nxt = (cz == CW'(eds_pkg::MAX_NZ - 1)) ? '0 : cz + CW'(1);
      end
    end
  end

  assign wr_ptr_nxt = (wr_ptr_r == LAST_ADDR) ? '0 : wr_ptr_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      pos_z_r  <= '0;
      wr_ptr_r <= '0;
    end else if (accept) begin
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      pos_z_r  <= pos_z_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  // Neighbor distances back in the stream
  always_comb begin
    d_c  = AW'(dims.plane);
    d_xp = AW'(dims.plane) - AW'(1);
    d_xm = AW'(dims.plane) + AW'(1);
    d_yp = AW'(dims.plane) - AW'(dims.nx);
    d_ym = AW'(dims.plane) + AW'(dims.nx);
    d_zm = AW'(dims.plane) << 1;
  end

  assign a_c  = back_addr(wr_ptr_r, d_c);
  assign a_xp = back_addr(wr_ptr_r, d_xp);
  assign a_xm = back_addr(wr_ptr_r, d_xm);
  assign a_yp = back_addr(wr_ptr_r, d_yp);
  assign a_ym = back_addr(wr_ptr_r, d_ym);
  assign a_zm = back_addr(wr_ptr_r, d_zm);

  // History banks: same write, two reads each
  always_ff @(posedge clk) begin
    if (accept) begin
      mem0[wr_ptr_r] <= in_data.cell_value;
    end
    if (load_taps) begin
      c_r  <= mem0[a_c];
      xp_r <= mem0[a_xp];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem1[wr_ptr_r] <= in_data.cell_value;
    end
    if (load_taps) begin
      xm_r <= mem1[a_xm];
      yp_r <= mem1[a_yp];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem2[wr_ptr_r] <= in_data.cell_value;
    end
    if (load_taps) begin
      ym_r <= mem2[a_ym];
      zm_r <= mem2[a_zm];
    end
  end

  // Stage 1 payload besides the memory reads
  always_ff @(posedge clk) begin
    if (load_taps) begin
      zp_r   <= in_data.cell_value;
      s1_x_r <= cx;
      s1_y_r <= cy;
      s1_z_r <= cz - CW'(1);
    end
  end

  // Only interior centers travel on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid && interior;
    end
  end

  assign s1_valid = s1_valid_r;

  always_comb begin
    s1_taps.c      = c_r;
    s1_taps.xm     = xm_r;
    s1_taps.xp     = xp_r;
    s1_taps.ym     = ym_r;
    s1_taps.yp     = yp_r;
    s1_taps.zm     = zm_r;
    s1_taps.zp     = zp_r;
    s1_taps.cell_x = s1_x_r;
    s1_taps.cell_y = s1_y_r;
    s1_taps.cell_z = s1_z_r;
  end

  // Checks
  a_wr_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> wr_ptr_r == (($past(wr_ptr_r) == LAST_ADDR) ? '0 : $past(wr_ptr_r) + AW'(1)))
    else $error("write pointer did not advance by one on a transaction");

  a_wr_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r <= LAST_ADDR)
    else $error("write pointer beyond history depth");

  a_s1_interior: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_x_r != '0) && (s1_y_r != '0))
    else $error("boundary center entered the arithmetic pipeline");

endmodule
`default_nettype wire

// ----- rtl/eds_arith.sv -----
`default_nettype none
// ============================================================================
// eds_arith
// Stencil arithmetic pipeline: second differences, coefficient products,
// partial sums, final sum with rounding and saturation into the output
// register. Each stage holds its item while the next one is full and stalled.
// ============================================================================
module eds_arith (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               s1_valid,
  output logic                    s1_ready,
  input  wire eds_pkg::taps_t     s1_taps,
  input  wire eds_pkg::coefs_t    coefs,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output eds_pkg::out_item_t      out_data
);

  localparam int DW  = eds_pkg::DIFF_W;
  localparam int PW  = eds_pkg::PROD_W;
  localparam int AW  = eds_pkg::ACC_W;
  localparam int RW  = eds_pkg::RES_W;
  localparam int VW  = eds_pkg::VAL_W;
  localparam int KW  = eds_pkg::COEF_W;
  localparam int CW  = eds_pkg::COORD_W;
  localparam int FS  = eds_pkg::FRAC_SHIFT;
  localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (FS - 1);

  // Stage valids and ready chain
  logic s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid_r || out_ready;
  assign rdy4     = !s4_valid_r || rdy5;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign s1_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy2) s2_valid_r  <= s1_valid;
      if (rdy3) s3_valid_r  <= s2_valid_r;
      if (rdy4) s4_valid_r  <= s3_valid_r;
      if (rdy5) out_valid_r <= s4_valid_r;
    end
  end

  // Stage 2: second differences
  logic signed [DW-1:0] e_c, e_xm, e_xp, e_ym, e_yp, e_zm, e_zp;
  logic signed [DW-1:0] dxx_nxt, dyy_nxt, dzz_nxt;
  logic signed [DW-1:0] dxx_r, dyy_r, dzz_r;
  logic signed [VW-1:0] s2_c_r;
  logic [CW-1:0]        s2_x_r, s2_y_r, s2_z_r;

  always_comb begin
    e_c  = DW'(s1_taps.c);
    e_xm = DW'(s1_taps.xm);
    e_xp = DW'(s1_taps.xp);
    e_ym = DW'(s1_taps.ym);
    e_yp = DW'(s1_taps.yp);
    e_zm = DW'(s1_taps.zm);
    e_zp = DW'(s1_taps.zp);
    dxx_nxt = e_xm + e_xp - (e_c <<< 1);
    dyy_nxt = e_ym + e_yp - (e_c <<< 1);
    dzz_nxt = e_zm + e_zp - (e_c <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      dxx_r  <= dxx_nxt;
      dyy_r  <= dyy_nxt;
      dzz_r  <= dzz_nxt;
      s2_c_r <= s1_taps.c;
      s2_x_r <= s1_taps.cell_x;
      s2_y_r <= s1_taps.cell_y;
      s2_z_r <= s1_taps.cell_z;
    end
  end

  // Stage 3: coefficient products
  logic signed [KW:0]   kx, ky, kz;
  logic signed [PW-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic signed [VW-1:0] s3_c_r;
  logic [CW-1:0]        s3_x_r, s3_y_r, s3_z_r;

  always_comb begin
    kx = {1'b0, coefs.cx};
    ky = {1'b0, coefs.cy};
    kz = {1'b0, coefs.cz};
    px_nxt = PW'(dxx_r) * PW'(kx);
    py_nxt = PW'(dyy_r) * PW'(ky);
    pz_nxt = PW'(dzz_r) * PW'(kz);
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_valid_r) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      s3_c_r <= s2_c_r;
      s3_x_r <= s2_x_r;
      s3_y_r <= s2_y_r;
      s3_z_r <= s2_z_r;
    end
  end

  // Stage 4: partial sums, rounding offset folded in
  logic signed [AW-1:0] c_ext, px_ext, py_ext, pz_ext;
  logic signed [AW-1:0] sum_a_nxt, sum_b_nxt;
  logic signed [AW-1:0] sum_a_r, sum_b_r;
  logic [CW-1:0]        s4_x_r, s4_y_r, s4_z_r;

  always_comb begin
    c_ext  = AW'(s3_c_r);
    px_ext = AW'(px_r);
    py_ext = AW'(py_r);
    pz_ext = AW'(pz_r);
    sum_a_nxt = (c_ext <<< FS) + ROUND_HALF + px_ext;
    sum_b_nxt = py_ext + pz_ext;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_valid_r) begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      s4_x_r  <= s3_x_r;
      s4_y_r  <= s3_y_r;
      s4_z_r  <= s3_z_r;
    end
  end

  // Stage 5: final sum, floor shift, saturation
  logic signed [AW-1:0] acc;
  logic [RW-1:0]        res;
  logic [VW-1:0]        sat_nxt;
  logic [VW-1:0]        val_r;
  logic [CW-1:0]        o_x_r, o_y_r, o_z_r;

  always_comb begin
    acc = sum_a_r + sum_b_r;
    res = acc[AW-1:FS];
    if ((&res[RW-1:VW-1]) || !(|res[RW-1:VW-1])) begin
      sat_nxt = res[VW-1:0];
    end else if (res[RW-1]) begin
      sat_nxt = eds_pkg::SAT_MIN;
    end else begin
      sat_nxt = eds_pkg::SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && s4_valid_r) begin
      val_r <= sat_nxt;
      o_x_r <= s4_x_r;
      o_y_r <= s4_y_r;
      o_z_r <= s4_z_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_data.updated_value = val_r;
    out_data.cell_x        = o_x_r;
    out_data.cell_y        = o_y_r;
    out_data.cell_z        = o_z_r;
  end

  // Checks
  a_fill_out: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r && rdy5 |=> out_valid_r)
    else $error("stage 4 transaction lost on the way to the output register");

  a_drain_out: assert property (@(posedge clk) disable iff (!rst_n)
    !s4_valid_r && out_valid_r && out_ready |=> !out_valid_r)
    else $error("result repeated after it was taken");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(val_r) && $stable(o_x_r) &&
                                  $stable(o_y_r) && $stable(o_z_r))
    else $error("waiting result changed before it was taken");

endmodule
`default_nettype wire

// ----- rtl/explicit_diffusion_stencil_3d.sv -----
`default_nettype none
// ============================================================================
// explicit_diffusion_stencil_3d
// Streaming 7-point FTCS heat-equation update over a 3D grid in raster order.
// ============================================================================
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------
//  in       | in_valid, in_ready, in_data      | one grid cell, x fastest
//  out      | out_valid, out_ready, out_data   | one updated interior center
//  cfg      | cfg_we, cfg_addr, cfg_wdata      | register write, no wait
//
//  Takes one cell transaction per clock while in_ready is high. out_valid rises
//  when the center's plus-z neighbor is accepted and has passed the registered
//  history read, differences, multipliers and two adder stages; non-interior
//  cells make no result or bubble. Reset clears positions, pointers and valids;
//  the history store has no clearing pass. With out_ready low the stages fill up
//  one by one and in_ready drops only when every stage holds an item.
//
module explicit_diffusion_stencil_3d (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire eds_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output eds_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_we,
  input  wire logic [eds_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire logic [eds_pkg::COEF_W-1:0]          cfg_wdata
);

  localparam int DW = eds_pkg::DIM_W;
  localparam int PP = 2 * eds_pkg::DIM_W;

  eds_pkg::coefs_t coefs_r, coefs_nxt;
  eds_pkg::dims_t  dims_r, dims_nxt;
  logic [DW-1:0]   dim_new;
  logic [PP-1:0]   plane_prod;

  // Configuration registers; dims are stored clamped with their plane size
  always_comb begin
    coefs_nxt  = coefs_r;
    dims_nxt   = dims_r;
    dim_new    = eds_pkg::clamp_dim(cfg_wdata[DW-1:0], eds_pkg::MAX_NX);
    plane_prod = '0;
    if (cfg_we) begin
      case (cfg_addr)
        eds_pkg::CFG_COEF_X: coefs_nxt.cx = cfg_wdata;
        eds_pkg::CFG_COEF_Y: coefs_nxt.cy = cfg_wdata;
        eds_pkg::CFG_COEF_Z: coefs_nxt.cz = cfg_wdata;
        eds_pkg::CFG_GRID_NX: begin
          dim_new        = eds_pkg::clamp_dim(cfg_wdata[DW-1:0], eds_pkg::MAX_NX);
          plane_prod     = PP'(dim_new) * PP'(dims_r.ny);
          dims_nxt.nx    = dim_new;
          dims_nxt.plane = plane_prod[eds_pkg::PLANE_W-1:0];
        end
        eds_pkg::CFG_GRID_NY: begin
          dim_new        = eds_pkg::clamp_dim(cfg_wdata[DW-1:0], eds_pkg::MAX_NY);
          plane_prod     = PP'(dims_r.nx) * PP'(dim_new);
          dims_nxt.ny    = dim_new;
          dims_nxt.plane = plane_prod[eds_pkg::PLANE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r      <= '0;
      dims_r.nx    <= DW'(eds_pkg::MAX_NX);
      dims_r.ny    <= DW'(eds_pkg::MAX_NY);
      dims_r.plane <= eds_pkg::PLANE_W'(eds_pkg::MAX_NX * eds_pkg::MAX_NY);
    end else begin
      coefs_r <= coefs_nxt;
      dims_r  <= dims_nxt;
    end
  end

  // Window store and neighbor fetch
  logic            s1_valid;
  logic            s1_ready;
  eds_pkg::taps_t  s1_taps;

  eds_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dims     (dims_r),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_taps  (s1_taps)
  );

  // Arithmetic pipeline and output register
  eds_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_taps   (s1_taps),
    .coefs     (coefs_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// ============================================================================
// tb
// Bench for the 3D explicit diffusion stencil. Cells are streamed in raster
// order through a valid/ready channel, with random gaps on the sender side
// and random backpressure on the result side. A scoreboard keeps its own
// copy of the two-plane history and the registers, computes each interior
// update exactly in 64-bit integers, and checks results in order.
// ============================================================================
module tb;

  localparam int VW  = eds_pkg::VAL_W;
  localparam int KW  = eds_pkg::COEF_W;
  localparam int DW  = eds_pkg::DIM_W;
  localparam int CRW = eds_pkg::COORD_W;
  localparam int IW  = eds_pkg::CFG_IDX_W;
  localparam int FS  = eds_pkg::FRAC_SHIFT;
  localparam int WD  = eds_pkg::WIN_DEPTH;

  // Expected-update predictor and result checker
  class diffusion_scoreboard;
    int                 history [WD];
    int unsigned        head, filled;
    int unsigned        px, py, pz;
    logic [KW-1:0]      kx, ky, kz;
    logic [DW-1:0]      nx_reg, ny_reg;
    eds_pkg::out_item_t update_q [$];
    int                 errors;

    function new();
      head   = 0;
      filled = 0;
      px     = 0;
      py     = 0;
      pz     = 0;
      kx     = '0;
      ky     = '0;
      kz     = '0;
      nx_reg = DW'(eds_pkg::MAX_NX);
      ny_reg = DW'(eds_pkg::MAX_NY);
      errors = 0;
    endfunction

    function int unsigned span(logic [DW-1:0] v, int unsigned hi);
      if (v < eds_pkg::MIN_DIM) return eds_pkg::MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned row_len();
      return span(nx_reg, eds_pkg::MAX_NX);
    endfunction

    function int unsigned col_len();
      return span(ny_reg, eds_pkg::MAX_NY);
    endfunction

    function void write_reg(eds_pkg::cfg_idx_t idx, logic [KW-1:0] val);
      case (idx)
        eds_pkg::CFG_COEF_X:  kx = val;
        eds_pkg::CFG_COEF_Y:  ky = val;
        eds_pkg::CFG_COEF_Z:  kz = val;
        eds_pkg::CFG_GRID_NX: nx_reg = val[DW-1:0];
        eds_pkg::CFG_GRID_NY: ny_reg = val[DW-1:0];
        default: ;
      endcase
    endfunction

    // value written 'back' cells before the newest one
    function longint tap(int unsigned back);
      return longint'(history[(head + WD - back) % WD]);
    endfunction

    function bit interior(int unsigned x, int unsigned y, int unsigned z,
                          int unsigned nx, int unsigned ny);
      return z >= 2 && x >= 1 && x + 2 <= nx && y >= 1 && y + 2 <= ny;
    endfunction

    // True when the next cell, continuing the stream, would need history
    // that has not been filled since reset.
    function bit reads_unwritten();
      int unsigned nx, ny;
      nx = row_len();
      ny = col_len();
      return interior(px, py, pz, nx, ny) && filled + 1 <= 2 * nx * ny;
    endfunction

    function void note_input(eds_pkg::in_item_t beat);
      int unsigned        nx, ny, plane, x, y, z;
      longint             c, dxx, dyy, dzz, acc, r;
      eds_pkg::out_item_t upd;
      nx    = row_len();
      ny    = col_len();
      plane = nx * ny;
      if (beat.grid_start) begin
        x = 0;
        y = 0;
        z = 0;
      end else begin
        x = px;
        y = py;
        z = pz;
      end
      history[head] = beat.cell_value;
      if (filled < WD) filled++;

      // the new cell is the plus-z neighbor of the center one plane back
      if (interior(x, y, z, nx, ny)) begin
        c   = tap(plane);
        dxx = tap(plane - 1) + tap(plane + 1) - 2 * c;
        dyy = tap(plane - nx) + tap(plane + nx) - 2 * c;
        dzz = longint'(beat.cell_value) + tap(2 * plane) - 2 * c;
        acc = (c <<< FS) + dxx * longint'(kx) + dyy * longint'(ky)
              + dzz * longint'(kz);
        // round half up, then saturate to 32 bits
        r = (acc + (longint'(1) <<< (FS - 1))) >>> FS;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        else if (r < -64'sd2147483648) r = -64'sd2147483648;
        upd.updated_value = r[VW-1:0];
        upd.cell_x        = CRW'(x);
        upd.cell_y        = CRW'(y);
        upd.cell_z        = CRW'(z - 1);
        update_q.push_back(upd);
      end

      head = (head + 1) % WD;
      x++;
      if (x >= nx) begin
        x = 0;
        y++;
        if (y >= ny) begin
          y = 0;
          z++;
          if (z >= eds_pkg::MAX_NZ) z = 0;
        end
      end
      px = x;
      py = y;
      pz = z;
    endfunction

    function void check_result(eds_pkg::out_item_t got);
      eds_pkg::out_item_t want;
      if (update_q.size() == 0) begin
        $error("unexpected result at (%0d,%0d,%0d) value %0d",
               got.cell_x, got.cell_y, got.cell_z, got.updated_value);
        errors++;
        return;
      end
      want = update_q.pop_front();
      if (got.updated_value !== want.updated_value) begin
        $error("updated_value: expected %0d, got %0d", want.updated_value,
               got.updated_value);
        errors++;
      end
      if (got.cell_x !== want.cell_x) begin
        $error("cell_x: expected %0d, got %0d", want.cell_x, got.cell_x);
        errors++;
      end
      if (got.cell_y !== want.cell_y) begin
        $error("cell_y: expected %0d, got %0d", want.cell_y, got.cell_y);
        errors++;
      end
      if (got.cell_z !== want.cell_z) begin
        $error("cell_z: expected %0d, got %0d", want.cell_z, got.cell_z);
        errors++;
      end
    endfunction

    function int pending();
      return update_q.size();
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  eds_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  eds_pkg::out_item_t out_data;
  logic               cfg_we    = 1'b0;
  logic [IW-1:0]      cfg_addr  = '0;
  logic [KW-1:0]      cfg_wdata = '0;

  diffusion_scoreboard sb = new();
  int unsigned cycle_count  = 0;
  int unsigned cells_sent   = 0;

  explicit_diffusion_stencil_3d dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Result-side backpressure, with one long stretch of no stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= 150 && cycle_count < 450) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 12);
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // One cell transaction, with an occasional idle cycle before it
  task automatic push_cell(eds_pkg::in_item_t beat);
    if ((cells_sent < 100 || cells_sent >= 250) && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sb.note_input(beat);
    cells_sent++;
  endtask

  // Stop sending and let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apply_config(input logic [KW-1:0] cx, cy, cz,
                              input logic [DW-1:0] nx, ny);
    eds_pkg::cfg_idx_t order [5];
    logic [KW-1:0]     vals  [5];
    order = '{eds_pkg::CFG_COEF_X, eds_pkg::CFG_COEF_Y, eds_pkg::CFG_COEF_Z,
              eds_pkg::CFG_GRID_NX, eds_pkg::CFG_GRID_NY};
    vals  = '{cx, cy, cz, KW'(nx), KW'(ny)};
    foreach (order[i]) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= order[i];
      cfg_wdata <= vals[i];
      sb.write_reg(order[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [VW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(VW-1){1'b0}}};
      1:       return {1'b0, {(VW-1){1'b1}}};
      2:       return $signed($urandom_range(0, 2)) - 1;
      3, 4, 5: return $urandom;
      default: return $signed($urandom) >>> 11;
    endcase
  endfunction

  function automatic logic [KW-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 24'h80_0000;
      3:       return KW'($urandom_range(0, 24'h03_FFFF));
      default: return KW'($urandom);
    endcase
  endfunction

  // mostly small grids; now and then a value that gets clamped
  function automatic logic [DW-1:0] pick_dim();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return DW'($urandom_range(0, 2));
    if (roll == 1) return DW'($urandom_range(65, 127));
    return DW'($urandom_range(3, 7));
  endfunction

  // Stream random cells; a start mark opens a fresh grid, and stray marks
  // mid-grid break the sequence. History that was never filled is not read.
  task automatic send_grid(int unsigned cells, bit fresh, int unsigned stray_pct);
    eds_pkg::in_item_t beat;
    for (int unsigned i = 0; i < cells; i++) begin
      beat.cell_value = pick_value();
      beat.grid_start = (i == 0) && fresh;
      if (i != 0 && $urandom_range(0, 99) < stray_pct) beat.grid_start = 1'b1;
      if (!beat.grid_start && sb.reads_unwritten()) beat.grid_start = 1'b1;
      push_cell(beat);
    end
  endtask

  // Main sequence
  initial begin
    eds_pkg::in_item_t beat;
    int unsigned       plane, cells;
    logic [KW-1:0]     cx, cy, cz;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturation both ways: 3x3 grid, four planes, full-scale coefficients
    apply_config('1, '1, '1, 3, 3);
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 9; k++) begin
        beat.grid_start = (p == 0 && k == 0);
        case (p)
          1:       beat.cell_value = (k == 4) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          2:       beat.cell_value = (k == 4) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          default: beat.cell_value = 32'sh7FFF_FFFF;
        endcase
        push_cell(beat);
      end
    end

    // Random phases; some continue the old stream under new dimensions
    while (cells_sent < 450) begin
      drain();
      if ($urandom_range(0, 6) == 0) begin
        // half-step coefficients make exact rounding ties common
        cx = $urandom_range(0, 1) ? 24'h80_0000 : '0;
        cy = $urandom_range(0, 1) ? 24'h80_0000 : '0;
        cz = $urandom_range(0, 1) ? 24'h80_0000 : '0;
      end else begin
        cx = pick_coef();
        cy = pick_coef();
        cz = pick_coef();
      end
      apply_config(cx, cy, cz, pick_dim(), pick_dim());
      plane = sb.row_len() * sb.col_len();
      repeat ($urandom_range(1, 2)) begin
        cells = plane * ((plane <= 36) ? $urandom_range(3, 5) : 3);
        if (cells > 200) cells = 200;
        if ($urandom_range(0, 99) < 15) cells = $urandom_range(1, cells);
        if (cells > 450 - cells_sent) cells = 450 - cells_sent;
        send_grid(cells, $urandom_range(0, 99) >= 20,
                  ($urandom_range(0, 3) == 0) ? 3 : 0);
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("PASS explicit_diffusion_stencil_3d");
    end else begin
      $display("FAIL explicit_diffusion_stencil_3d");
    end
    $finish;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("FAIL explicit_diffusion_stencil_3d");
    $finish;
  end

endmodule
